// ===== design/urbd_pkg.sv =====
`default_nettype none

package urbd_pkg;

    localparam int DATA_W = 8;
    localparam int CMD_W  = 3;
    localparam int FILL_W = 6;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNTIL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LINE  = 3'd5;

    localparam logic [DATA_W-1:0] CH_NUL = 8'h00;
    localparam logic [DATA_W-1:0] CH_LF  = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR  = 8'h0D;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              has_data;
        logic              found;
        logic              last;
        logic [FILL_W-1:0] fill_count;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } emit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_DLV_RD,
        ST_DLV_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== design/urbd_ram.sv =====
`default_nettype none

module urbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/urbd_ctrl.sv =====
`default_nettype none

module urbd_ctrl #(
    parameter int DEPTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire urbd_pkg::item_t                 item,
    input  wire logic [urbd_pkg::DATA_W-1:0]     delimiter,
    output logic                                 busy,
    output urbd_pkg::emit_t                      emit
);

    localparam int IW = $clog2(DEPTH);
    localparam int FW = urbd_pkg::FILL_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(DEPTH);

    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] fill_of(input logic [IW-1:0] h, input logic [IW-1:0] t);
        logic [IW:0] d;
        d = {1'b0, t} - {1'b0, h};
        if (t < h)
        begin
            d = d + DEPTH_X;
        end
        return IW'(d);
    endfunction

    urbd_pkg::state_t state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          ovf_reg, ovf_next;
    logic [urbd_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [IW-1:0] off_reg, off_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] rem_reg, rem_next;
    logic [IW-1:0] scan_addr_reg, scan_addr_next;
    logic          cr_reg, cr_next;

    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    logic [urbd_pkg::DATA_W-1:0] ram_wdata;
    logic [IW-1:0]               ram_raddr;
    logic [urbd_pkg::DATA_W-1:0] ram_rdata;

    logic          accept;
    logic          full;
    logic          empty;
    logic          until_hit;
    logic          line_hit;
    logic          hit;
    logic          scan_last;
    logic [IW-1:0] hit_pos;
    logic          two_skip;
    logic          dlv_final;
    logic [IW-1:0] head_inc;

    urbd_ram #(
        .WIDTH (urbd_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != urbd_pkg::ST_IDLE);
    assign accept    = start && (state_reg == urbd_pkg::ST_IDLE);
    assign full      = (wrap_next(tail_reg) == head_reg);
    assign empty     = (head_reg == tail_reg);
    assign until_hit = (cmd_reg == urbd_pkg::CMD_UNTIL) && (ram_rdata == delimiter);
    assign line_hit  = (cmd_reg == urbd_pkg::CMD_LINE) && cr_reg
                       && (ram_rdata == urbd_pkg::CH_LF);
    assign hit       = (state_reg == urbd_pkg::ST_SCAN) && (until_hit || line_hit);
    assign scan_last = (({1'b0, off_reg} + 1'b1) == {1'b0, cnt_reg});
    assign hit_pos   = until_hit ? off_reg : off_reg - 1'b1;
    assign two_skip  = (cmd_reg == urbd_pkg::CMD_LINE);
    assign dlv_final = (rem_reg == IW'(1));
    assign head_inc  = wrap_next(head_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            urbd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.cmd)
                        urbd_pkg::CMD_POP, urbd_pkg::CMD_PEEK:
                        begin
                            if (!empty)
                            begin
                                state_next = urbd_pkg::ST_POP;
                            end
                        end
                        urbd_pkg::CMD_UNTIL, urbd_pkg::CMD_LINE:
                        begin
                            if (!empty)
                            begin
                                state_next = urbd_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = urbd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            urbd_pkg::ST_POP:
            begin
                state_next = urbd_pkg::ST_IDLE;
            end
            urbd_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = (hit_pos == '0) ? urbd_pkg::ST_IDLE : urbd_pkg::ST_DLV_RD;
                end
                else if (scan_last)
                begin
                    state_next = urbd_pkg::ST_IDLE;
                end
            end
            urbd_pkg::ST_DLV_RD:
            begin
                state_next = urbd_pkg::ST_DLV_OUT;
            end
            urbd_pkg::ST_DLV_OUT:
            begin
                if (dlv_final)
                begin
                    state_next = urbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = urbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        ovf_next       = ovf_reg;
        cmd_next       = cmd_reg;
        off_next       = off_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        scan_addr_next = scan_addr_reg;
        cr_next        = cr_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = item.rx_byte;
        ram_raddr      = head_reg;
        emit           = '0;
        emit.res.last  = 1'b1;

        unique case (state_reg)
            urbd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = item.cmd;
                    off_next       = '0;
                    cnt_next       = fill_of(head_reg, tail_reg);
                    scan_addr_next = head_reg;
                    cr_next        = 1'b0;
                    unique case (item.cmd)
                        urbd_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                tail_next = wrap_next(tail_reg);
                            end
                            emit.valid = 1'b1;
                        end
                        urbd_pkg::CMD_POP, urbd_pkg::CMD_PEEK,
                        urbd_pkg::CMD_UNTIL, urbd_pkg::CMD_LINE:
                        begin
                            emit.valid = empty;
                        end
                        urbd_pkg::CMD_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            emit.valid = 1'b1;
                        end
                        default:
                        begin
                            emit.valid = 1'b1;
                        end
                    endcase
                end
            end
            urbd_pkg::ST_POP:
            begin
                emit.valid        = 1'b1;
                emit.res.data     = ram_rdata;
                emit.res.has_data = 1'b1;
                emit.res.found    = 1'b1;
                if (cmd_reg == urbd_pkg::CMD_POP)
                begin
                    head_next = head_inc;
                end
            end
            urbd_pkg::ST_SCAN:
            begin
                ram_raddr      = wrap_next(scan_addr_reg);
                cr_next        = (ram_rdata == urbd_pkg::CH_CR);
                off_next       = off_reg + 1'b1;
                scan_addr_next = wrap_next(scan_addr_reg);
                if (hit)
                begin
                    rem_next = hit_pos;
                    if (hit_pos == '0)
                    begin
                        head_next      = two_skip ? wrap_next(head_inc) : head_inc;
                        emit.valid     = 1'b1;
                        emit.res.found = 1'b1;
                    end
                end
                else if (scan_last)
                begin
                    emit.valid = 1'b1;
                end
            end
            urbd_pkg::ST_DLV_RD:
            begin
                ram_raddr = head_reg;
            end
            urbd_pkg::ST_DLV_OUT:
            begin
                ram_raddr         = head_inc;
                emit.valid        = 1'b1;
                emit.res.data     = ram_rdata;
                emit.res.has_data = 1'b1;
                emit.res.found    = 1'b1;
                emit.res.last     = dlv_final;
                rem_next          = rem_reg - 1'b1;
                if (dlv_final)
                begin
                    // consume the delimiter or the CR LF pair with the final byte
                    head_next = two_skip ? wrap_next(wrap_next(head_inc))
                                         : wrap_next(head_inc);
                end
                else
                begin
                    head_next = head_inc;
                end
            end
            default:
            begin
                emit.valid = 1'b0;
            end
        endcase

        emit.res.fill_count = FW'(fill_of(head_next, tail_next));
        emit.res.overflow   = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= urbd_pkg::ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        off_reg       <= off_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        scan_addr_reg <= scan_addr_next;
        cr_reg        <= cr_next;
    end

endmodule

`default_nettype wire

// ===== design/uart_rx_ring_buffer_delimited.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Word
// command   in         start, busy               item (cmd, rx_byte)
// result    out        result_valid (no stall)   result (data .. overflow)
// config    in         cfg_valid, cfg_ready      cfg_data (delimiter)
//
// Push, clear and unused codes: result in the cycle after start, busy stays low.
// Pop and peek: one ring read in the pop state, its data registered as the result.
// Read-until and read-line: one stored byte scanned per cycle through the ring's
// single read port, then a head read state and an output state that delivers the bytes.
// Reset clears head, tail, overflow and the delimiter; ring contents need no clearing.
// Results are never held off: each result word shows for one cycle only.

module uart_rx_ring_buffer_delimited #(
    parameter int DEPTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire urbd_pkg::item_t             item,
    output logic                             result_valid,
    output urbd_pkg::result_t                result,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [urbd_pkg::DATA_W-1:0] cfg_data
);

    logic [urbd_pkg::DATA_W-1:0] delimiter_reg;
    logic                        result_valid_reg;
    urbd_pkg::result_t           result_reg;
    urbd_pkg::emit_t             emit;

    urbd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .delimiter (delimiter_reg),
        .busy      (busy),
        .emit      (emit)
    );

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg    <= urbd_pkg::CH_NUL;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                delimiter_reg <= cfg_data;
            end
            result_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            result_reg <= emit.res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_single_cycle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.cmd == urbd_pkg::CMD_PUSH || item.cmd == urbd_pkg::CMD_CLEAR))
        |=> (result_valid && result.last && !result.has_data))
        else $error("push or clear did not return a single result");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(result_valid) && $past(result.overflow)) |-> result.overflow)
        else $error("overflow flag cleared without reset");

    a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.has_data) |-> (result.data == '0))
        else $error("data nonzero without a delivered byte");

    a_data_found: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.has_data) |-> result.found)
        else $error("delivered byte without found");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("run ended before its last result");

endmodule

`default_nettype wire

// ===== dv/tb_uart_rx_ring_buffer_delimited.sv =====
module tb_uart_rx_ring_buffer_delimited;

    import urbd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 160;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_GAP       = 17;

    typedef enum logic [1:0] {
        OP_WORD,
        OP_DELIM_WR,
        OP_DRAIN
    } host_kind_t;

    typedef struct {
        host_kind_t        kind;
        item_t             word;
        logic [DATA_W-1:0] value;
        int                gap;
    } host_op_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    item_t             item = '0;
    logic              result_valid;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [DATA_W-1:0] cfg_data = '0;

    host_op_t host_ops[$];
    result_t  expected_words[$];

    logic [DATA_W-1:0] ring_mem [64];
    logic [FILL_W-1:0] head_ix;
    logic [FILL_W-1:0] tail_ix;
    logic              ovf_flag;
    logic [DATA_W-1:0] delim_q;

    int gap_cnt;
    int quiet_cnt;
    int idle_cycles;
    int errors = 0;

    int burst_left = 0;
    logic [DATA_W-1:0] gen_delim = CH_NUL;

    uart_rx_ring_buffer_delimited u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        $display("mismatch %s: expected 'h%0h, got 'h%0h at %0t", what, want, got, $time);
        errors++;
    endtask

    function automatic void expect_word(input logic [DATA_W-1:0] data, input logic has,
                                        input logic found, input logic last);
        result_t w;
        w.data       = data;
        w.has_data   = has;
        w.found      = found;
        w.last       = last;
        w.fill_count = tail_ix - head_ix;
        w.overflow   = ovf_flag;
        expected_words.push_back(w);
    endfunction

    function automatic void hand_out_run(input int pos, input int skip);
        logic [DATA_W-1:0] b;
        if (pos == 0)
        begin
            head_ix = head_ix + FILL_W'(skip);
            expect_word(CH_NUL, 1'b0, 1'b1, 1'b1);
        end
        else
        begin
            for (int i = 0; i < pos; i++)
            begin
                b = ring_mem[head_ix];
                head_ix = head_ix + 1'b1;
                if (i == pos - 1)
                    head_ix = head_ix + FILL_W'(skip);
                expect_word(b, 1'b1, 1'b1, i == pos - 1);
            end
        end
    endfunction

    function automatic void ring_apply(input item_t it);
        logic [FILL_W-1:0] fill;
        int                pos;
        fill = tail_ix - head_ix;
        pos  = -1;
        case (it.cmd)
            CMD_PUSH:
            begin
                if (FILL_W'(tail_ix + 1'b1) == head_ix)
                    ovf_flag = 1'b1;
                else
                begin
                    ring_mem[tail_ix] = it.rx_byte;
                    tail_ix = tail_ix + 1'b1;
                end
                expect_word(CH_NUL, 1'b0, 1'b0, 1'b1);
            end
            CMD_POP:
            begin
                if (fill == 0)
                    expect_word(CH_NUL, 1'b0, 1'b0, 1'b1);
                else
                begin
                    head_ix = head_ix + 1'b1;
                    expect_word(ring_mem[FILL_W'(head_ix - 1'b1)], 1'b1, 1'b1, 1'b1);
                end
            end
            CMD_PEEK:
            begin
                if (fill == 0)
                    expect_word(CH_NUL, 1'b0, 1'b0, 1'b1);
                else
                    expect_word(ring_mem[head_ix], 1'b1, 1'b1, 1'b1);
            end
            CMD_CLEAR:
            begin
                head_ix = '0;
                tail_ix = '0;
                expect_word(CH_NUL, 1'b0, 1'b0, 1'b1);
            end
            CMD_UNTIL:
            begin
                for (int n = 0; n < int'(fill); n++)
                    if (pos < 0 && ring_mem[FILL_W'(head_ix + FILL_W'(n))] == delim_q)
                        pos = n;
                if (pos >= 0)
                    hand_out_run(pos, 1);
                else
                    expect_word(CH_NUL, 1'b0, 1'b0, 1'b1);
            end
            CMD_LINE:
            begin
                for (int n = 0; n + 1 < int'(fill); n++)
                    if (pos < 0 && ring_mem[FILL_W'(head_ix + FILL_W'(n))] == CH_CR
                        && ring_mem[FILL_W'(head_ix + FILL_W'(n + 1))] == CH_LF)
                        pos = n;
                if (pos >= 0)
                    hand_out_run(pos, 2);
                else
                    expect_word(CH_NUL, 1'b0, 1'b0, 1'b1);
            end
            default:
                expect_word(CH_NUL, 1'b0, 1'b0, 1'b1);
        endcase
    endfunction

    function automatic void add_word(input logic [CMD_W-1:0] cmd,
                                     input logic [DATA_W-1:0] b);
        host_op_t op;
        op.kind         = OP_WORD;
        op.word.cmd     = cmd;
        op.word.rx_byte = b;
        op.value        = '0;
        if (burst_left > 0)
        begin
            op.gap = 0;
            burst_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            op.gap = 0;
            burst_left = $urandom_range(5, 20);
        end
        else
            op.gap = $urandom_range(0, MAX_GAP);
        host_ops.push_back(op);
    endfunction

    function automatic void add_ctrl(input host_kind_t kind, input logic [DATA_W-1:0] v);
        host_op_t op;
        op.kind  = kind;
        op.word  = '0;
        op.value = v;
        op.gap   = 0;
        host_ops.push_back(op);
    endfunction

    function automatic logic [DATA_W-1:0] plain_byte();
        logic [DATA_W-1:0] b;
        b = DATA_W'($urandom_range(0, 255));
        if (b == gen_delim)
            b = ~b;
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] any_byte();
        return DATA_W'($urandom_range(0, 255));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : host_drive
        logic nstart;
        logic ncfg;
        if (!rst_n)
        begin
            start     <= 1'b0;
            item      <= '0;
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
            gap_cnt   = 0;
            quiet_cnt = 0;
            head_ix   = '0;
            tail_ix   = '0;
            ovf_flag  = 1'b0;
            delim_q   = CH_NUL;
        end
        else
        begin
            nstart = start;
            ncfg   = cfg_valid;
            if (start && !busy)
            begin
                ring_apply(item);
                nstart = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                delim_q = cfg_data;
                ncfg    = 1'b0;
            end
            if (expected_words.size() == 0 && !busy && !nstart)
                quiet_cnt++;
            else
                quiet_cnt = 0;
            if (!nstart && !ncfg && host_ops.size() != 0)
            begin
                if (gap_cnt != 0)
                    gap_cnt--;
                else
                begin
                    case (host_ops[0].kind)
                        OP_WORD:
                        begin
                            if (host_ops[0].gap != 0)
                            begin
                                gap_cnt = host_ops[0].gap - 1;
                                host_ops[0].gap = 0;
                            end
                            else
                            begin
                                nstart = 1'b1;
                                item <= host_ops[0].word;
                                void'(host_ops.pop_front());
                            end
                        end
                        OP_DELIM_WR:
                        begin
                            if (quiet_cnt >= SETTLE_CYCLES)
                            begin
                                ncfg = 1'b1;
                                cfg_data <= host_ops[0].value;
                                void'(host_ops.pop_front());
                            end
                        end
                        default:
                        begin
                            if (quiet_cnt >= 1)
                                void'(host_ops.pop_front());
                        end
                    endcase
                end
            end
            start     <= nstart;
            cfg_valid <= ncfg;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_watch
        result_t want;
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if (result_valid)
            begin
                if (expected_words.size() == 0)
                    flag_mismatch("word with none expected", 0, result);
                else
                begin
                    want = expected_words.pop_front();
                    if (result.data !== want.data)
                        flag_mismatch("data", want.data, result.data);
                    if (result.has_data !== want.has_data)
                        flag_mismatch("has_data", want.has_data, result.has_data);
                    if (result.found !== want.found)
                        flag_mismatch("found", want.found, result.found);
                    if (result.last !== want.last)
                        flag_mismatch("last", want.last, result.last);
                    if (result.fill_count !== want.fill_count)
                        flag_mismatch("fill_count", want.fill_count, result.fill_count);
                    if (result.overflow !== want.overflow)
                        flag_mismatch("overflow", want.overflow, result.overflow);
                end
            end
            if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        int len;
        int made;
        logic drained;
        logic [DATA_W-1:0] d;

        // empty ring, spare codes, delimiter at head, CR/LF corner cases
        add_word(CMD_POP, 8'hFF);
        add_word(CMD_PEEK, 8'h00);
        add_word(CMD_UNTIL, 8'hFF);
        add_word(CMD_LINE, 8'h00);
        add_word(CMD_SPARE6, 8'h00);
        add_word(CMD_SPARE7, 8'hFF);
        add_word(CMD_PUSH, 8'h00);
        add_word(CMD_UNTIL, 8'h00);
        add_word(CMD_PUSH, 8'hFF);
        add_word(CMD_PUSH, CH_CR);
        add_word(CMD_LINE, 8'hFF);
        add_word(CMD_PUSH, 8'h55);
        add_word(CMD_PUSH, CH_CR);
        add_word(CMD_PUSH, CH_LF);
        add_word(CMD_LINE, 8'h00);
        add_word(CMD_PUSH, CH_CR);
        add_word(CMD_PUSH, CH_LF);
        add_word(CMD_LINE, 8'hAA);
        add_word(CMD_PUSH, 8'h80);
        add_word(CMD_PEEK, 8'h00);
        add_word(CMD_UNTIL, 8'h00);
        add_word(CMD_POP, 8'h00);
        add_word(CMD_PUSH, 8'h7F);
        add_word(CMD_CLEAR, 8'hFF);
        add_word(CMD_POP, 8'h00);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: d = 8'h00;
                1: d = 8'hFF;
                default: d = any_byte();
            endcase
            gen_delim = d;
            add_ctrl(OP_DELIM_WR, d);

            if (ph == 2)
            begin
                // fill to the brim, overrun, then drain it all in one read
                add_word(CMD_CLEAR, any_byte());
                for (int i = 0; i < 62; i++)
                    add_word(CMD_PUSH, plain_byte());
                add_word(CMD_PUSH, gen_delim);
                add_word(CMD_PUSH, plain_byte());
                add_word(CMD_PUSH, plain_byte());
                add_word(CMD_UNTIL, any_byte());
                add_word(CMD_PEEK, any_byte());
            end

            made    = 0;
            drained = 1'b0;
            while (made < 48)
            begin
                pick = $urandom_range(0, 9);
                len  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20)
                                                    : $urandom_range(0, 4);
                if (pick < 5)
                begin
                    for (int i = 0; i < len; i++)
                        add_word(CMD_PUSH, plain_byte());
                    add_word(CMD_PUSH, gen_delim);
                    add_word(CMD_UNTIL, any_byte());
                    made += len + 2;
                end
                else if (pick < 7)
                begin
                    for (int i = 0; i < len; i++)
                        add_word(CMD_PUSH, ($urandom_range(0, 5) == 0) ? CH_CR : any_byte());
                    add_word(CMD_PUSH, CH_CR);
                    add_word(CMD_PUSH, CH_LF);
                    add_word(CMD_LINE, any_byte());
                    made += len + 3;
                end
                else if (pick == 7)
                begin
                    add_word($urandom_range(0, 1) ? CMD_POP : CMD_PEEK, any_byte());
                    made++;
                end
                else if (pick == 8)
                begin
                    add_word(CMD_W'($urandom_range(0, 7)), any_byte());
                    made++;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: add_word(CMD_CLEAR, any_byte());
                        1: add_word(CMD_UNTIL, any_byte());
                        default: add_word(CMD_LINE, any_byte());
                    endcase
                    made++;
                end
                if (made >= 24 && !drained)
                begin
                    add_ctrl(OP_DRAIN, CH_NUL);
                    drained = 1'b1;
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (host_ops.size() != 0 || start || cfg_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_words.size() != 0)
            flag_mismatch("words never seen", 0, expected_words.size());

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== uart_rx_ring_buffer_delimited.f =====
design/urbd_pkg.sv
design/urbd_ram.sv
design/urbd_ctrl.sv
design/uart_rx_ring_buffer_delimited.sv
dv/tb_uart_rx_ring_buffer_delimited.sv
